// File: hdl/size_class_slab_allocator_macros.svh
// Assertion macros for the size-class slab allocator.
// Depends on nothing; included by the top level.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_MACROS_SVH

// Check cons in the same cycle as ante.
`define SCSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/scsa_pkg.sv
// Shared constants and types of the size-class slab allocator.
// Depends on nothing; imported by the top level and the testbench.
package scsa_pkg;

    localparam int unsigned HEAP_BYTES  = 1024 * 1024;
    localparam int unsigned SLOT_STRIDE = 8;
    localparam int unsigned NUM_CLASSES = 8;

    localparam int unsigned SLOT_COUNT = HEAP_BYTES / SLOT_STRIDE;
    localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
    localparam int unsigned STRIDE_SH  = $clog2(SLOT_STRIDE);
    localparam int unsigned CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    // Field widths
    localparam int unsigned REQ_W  = 21;
    localparam int unsigned OFF_W  = 21;
    localparam int unsigned ROFF_W = 20;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned ZB_W   = 21;

    // State widths
    localparam int unsigned CUR_W  = 21;
    localparam int unsigned TOK_W  = 18;
    localparam int unsigned TAG_W  = 5;

    // Rounded size and bump sum
    localparam int unsigned SIZE_W = REQ_W + 1;
    localparam int unsigned NEXT_W = SIZE_W + 1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_RECYCLED  = 3'd0,
        STAT_BUMPED    = 3'd1,
        STAT_ZERO_SIZE = 3'd2,
        STAT_EXHAUSTED = 3'd3,
        STAT_OUT_HEAP  = 3'd4,
        STAT_MISALIGN  = 3'd5,
        STAT_FREED     = 3'd6,
        STAT_LEAKED    = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_EVAL
    } state_t;

    // Tag codes: 0 uncarved, FREE(c) = c + 1, LIVE(c) = c + 1 + NUM_CLASSES
    function automatic logic [TAG_W-1:0] free_tag(input logic [CLS_W-1:0] c);
        return TAG_W'(c) + TAG_W'(1);
    endfunction

    function automatic logic [TAG_W-1:0] live_tag(input logic [CLS_W-1:0] c);
        return TAG_W'(c) + TAG_W'(1) + TAG_W'(NUM_CLASSES);
    endfunction

    function automatic logic [SIZE_W-1:0] class_size(input logic [CLS_W-1:0] c);
        return SIZE_W'(SLOT_STRIDE) << c;
    endfunction

endpackage

// File: hdl/scsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
module scsa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/size_class_slab_allocator.sv
// Top level of the size-class slab allocator: control, class heads, bump cursor.
// Depends on scsa_pkg, scsa_ram and size_class_slab_allocator_macros.svh.
//
// Usage
//   Request channel (req_valid/req_ready): operation, req_size, free_offset.
//   Response channel (rsp_valid/rsp_ready): result_offset, status, zero_bytes.
//   Every request gives exactly one response, in order.
//   A request is handled in steps: the accept edge registers it and decodes the
//   size class, the lookup state reads the class head and issues one read of
//   the slot tag and link memories, and the evaluate state checks the tag,
//   writes tag, link, head and cursor, and loads the response register.
//   The registered memory read lies between lookup and write-back; a new
//   request is taken only once the last one has been evaluated.
//   The response register holds a finished result while the next request is
//   taken and looked up; when the receiver stalls, the evaluate step waits
//   until the response register is free, so no state changes early.
//   After reset the block sweeps all SLOT_COUNT (131072) entries of the slot
//   tag memory to zero, one entry a cycle; req_ready stays low during it.
//   The slot link memory is not cleared.

`include "size_class_slab_allocator_macros.svh"

module size_class_slab_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic                        operation,
    input  logic [scsa_pkg::REQ_W-1:0]  req_size,
    input  logic [scsa_pkg::OFF_W-1:0]  free_offset,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [scsa_pkg::ROFF_W-1:0] result_offset,
    output logic [scsa_pkg::STAT_W-1:0] status,
    output logic [scsa_pkg::ZB_W-1:0]   zero_bytes
);

    import scsa_pkg::*;

    // Control state
    state_t               state_reg;
    state_t               state_next;
    logic [SLOT_W-1:0]    clr_cnt_reg;
    logic [SLOT_W-1:0]    clr_cnt_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic [CUR_W-1:0]     bump_cursor_reg;
    logic [TOK_W-1:0]     heads_reg [NUM_CLASSES];

    // Registered request
    op_t                  op_reg;
    logic [REQ_W-1:0]     req_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [SIZE_W-1:0]    rounded_reg;
    logic [CLS_W-1:0]     cls_reg;
    logic                 has_cls_reg;
    logic [TOK_W-1:0]     tok_reg;

    // Response payload
    logic [ROFF_W-1:0]    res_off_reg;
    status_t              stat_reg;
    logic [ZB_W-1:0]      zb_reg;

    // Control strobes
    logic                 accept;
    logic                 clearing;
    logic                 ev_go;

    // Class decode on the request port
    logic [SIZE_W-1:0]    rounded_c;
    logic [CLS_W-1:0]     cls_dec;
    logic                 has_cls_dec;

    // Head read port and memory lookup
    logic [CLS_W-1:0]     head_ridx;
    logic [TOK_W-1:0]     head_rd;
    logic [TOK_W-1:0]     pop_slot;
    logic [SLOT_W-1:0]    rd_addr;
    logic [SLOT_W-1:0]    off_slot;
    logic [TAG_W-1:0]     tag_rd;
    logic [TOK_W-1:0]     link_rd;

    // Evaluate step
    logic [TOK_W-1:0]     tok_slot;
    logic                 pop_ok;
    logic [SIZE_W-1:0]    size_bump;
    logic [NEXT_W-1:0]    next_cur;
    logic                 is_live;
    logic [CLS_W-1:0]     live_cls;
    logic [ZB_W-1:0]      room;
    logic [ROFF_W-1:0]    res_off_c;
    status_t              stat_c;
    logic [ZB_W-1:0]      zb_c;
    logic                 tag_we_c;
    logic [SLOT_W-1:0]    tag_waddr_c;
    logic [TAG_W-1:0]     tag_wdata_c;
    logic                 link_we_c;
    logic                 head_we_c;
    logic [CLS_W-1:0]     head_widx_c;
    logic [TOK_W-1:0]     head_wdata_c;
    logic                 cur_we_c;

    // Memory ports
    logic                 tag_we;
    logic [SLOT_W-1:0]    tag_waddr;
    logic [TAG_W-1:0]     tag_wdata;
    logic                 mem_re;

    //------------------------------------------------------------------
    // Next state
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == {SLOT_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Control outputs
    //------------------------------------------------------------------
    always_comb
    begin
        req_ready    = 1'b0;
        clearing     = 1'b0;
        ev_go        = 1'b0;
        mem_re       = 1'b0;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clearing     = 1'b1;
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
            end
            S_LOOK:
            begin
                mem_re = 1'b1;
            end
            S_EVAL:
            begin
                ev_go = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    assign accept = req_valid && req_ready;

    // Load the response register on evaluate; drop it once taken.
    assign rsp_valid_next = ev_go || (rsp_valid_reg && !rsp_ready);

    //------------------------------------------------------------------
    // Size class decode: round up to the stride, pick the smallest class
    //------------------------------------------------------------------
    assign rounded_c = (SIZE_W'(req_size) + SIZE_W'(SLOT_STRIDE - 1))
                       & ~SIZE_W'(SLOT_STRIDE - 1);

    always_comb
    begin
        cls_dec     = '0;
        has_cls_dec = 1'b0;
        // Scan downward so the smallest fitting class wins.
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (rounded_c <= class_size(CLS_W'(i)))
            begin
                cls_dec     = CLS_W'(i);
                has_cls_dec = 1'b1;
            end
        end
    end

    //------------------------------------------------------------------
    // Lookup: one head read, one slot read in the tag and link memories
    //------------------------------------------------------------------
    assign off_slot  = off_reg[STRIDE_SH +: SLOT_W];
    // Look up the request's class; in evaluate, the class of the freed slot.
    assign head_ridx = (state_reg == S_EVAL) ? live_cls : cls_reg;
    assign head_rd   = heads_reg[head_ridx];
    assign pop_slot  = head_rd - TOK_W'(1);
    assign rd_addr   = (op_reg == OP_FREE) ? off_slot : pop_slot[SLOT_W-1:0];

    assign tag_we    = clearing || (ev_go && tag_we_c);
    assign tag_waddr = clearing ? clr_cnt_reg : tag_waddr_c;
    assign tag_wdata = clearing ? '0 : tag_wdata_c;

    scsa_ram #(
        .WIDTH (TAG_W),
        .DEPTH (SLOT_COUNT)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (mem_re),
        .raddr (rd_addr),
        .rdata (tag_rd)
    );

    scsa_ram #(
        .WIDTH (TOK_W),
        .DEPTH (SLOT_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (ev_go && link_we_c),
        .waddr (off_slot),
        .wdata (head_rd),
        .re    (mem_re),
        .raddr (rd_addr),
        .rdata (link_rd)
    );

    //------------------------------------------------------------------
    // Evaluate: check tag, pick recycle, bump, free, leak or error, build result
    //------------------------------------------------------------------
    assign tok_slot  = tok_reg - TOK_W'(1);
    // A head is good only if its slot lies in the heap and is FREE of this class.
    assign pop_ok    = (tok_reg != '0) && (tok_slot < TOK_W'(SLOT_COUNT))
                       && (tag_rd == free_tag(cls_reg));
    assign size_bump = has_cls_reg ? class_size(cls_reg) : rounded_reg;
    assign next_cur  = NEXT_W'(bump_cursor_reg) + NEXT_W'(size_bump);
    assign is_live   = (tag_rd > TAG_W'(NUM_CLASSES))
                       && (tag_rd <= TAG_W'(2 * NUM_CLASSES));
    assign live_cls  = CLS_W'(tag_rd - TAG_W'(1) - TAG_W'(NUM_CLASSES));
    assign room      = ZB_W'(HEAP_BYTES) - ZB_W'(off_reg);

    always_comb
    begin
        res_off_c    = '0;
        stat_c       = STAT_ZERO_SIZE;
        zb_c         = '0;
        tag_we_c     = 1'b0;
        tag_waddr_c  = off_slot;
        tag_wdata_c  = '0;
        link_we_c    = 1'b0;
        head_we_c    = 1'b0;
        head_widx_c  = cls_reg;
        head_wdata_c = '0;
        cur_we_c     = 1'b0;
        case (op_reg)
            OP_ALLOC:
            begin
                if (req_reg == '0)
                begin
                    stat_c = STAT_ZERO_SIZE;
                end
                else if (has_cls_reg && pop_ok)
                begin
                    // Recycle: mark live, advance the head to the link.
                    stat_c       = STAT_RECYCLED;
                    res_off_c    = ROFF_W'(tok_slot[SLOT_W-1:0]) << STRIDE_SH;
                    tag_we_c     = 1'b1;
                    tag_waddr_c  = tok_slot[SLOT_W-1:0];
                    tag_wdata_c  = live_tag(cls_reg);
                    head_we_c    = 1'b1;
                    head_wdata_c = link_rd;
                end
                else
                begin
                    // Drop a corrupt head, then bump.
                    if (has_cls_reg && (tok_reg != '0))
                    begin
                        head_we_c    = 1'b1;
                        head_wdata_c = '0;
                    end
                    if (next_cur > NEXT_W'(HEAP_BYTES))
                    begin
                        stat_c = STAT_EXHAUSTED;
                    end
                    else
                    begin
                        stat_c      = STAT_BUMPED;
                        res_off_c   = bump_cursor_reg[ROFF_W-1:0];
                        zb_c        = size_bump[ZB_W-1:0];
                        cur_we_c    = 1'b1;
                        tag_we_c    = has_cls_reg;
                        tag_waddr_c = bump_cursor_reg[STRIDE_SH +: SLOT_W];
                        tag_wdata_c = live_tag(cls_reg);
                    end
                end
            end
            OP_FREE:
            begin
                if (off_reg >= OFF_W'(HEAP_BYTES))
                begin
                    stat_c = STAT_OUT_HEAP;
                end
                else if (off_reg[STRIDE_SH-1:0] != '0)
                begin
                    stat_c = STAT_MISALIGN;
                end
                else if (is_live)
                begin
                    // Push: mark free, link to the old head, head takes the slot.
                    stat_c       = STAT_FREED;
                    res_off_c    = off_reg[ROFF_W-1:0];
                    zb_c         = ZB_W'(class_size(live_cls));
                    tag_we_c     = 1'b1;
                    tag_wdata_c  = free_tag(live_cls);
                    link_we_c    = 1'b1;
                    head_we_c    = 1'b1;
                    head_widx_c  = live_cls;
                    head_wdata_c = TOK_W'(off_slot) + TOK_W'(1);
                end
                else
                begin
                    stat_c    = STAT_LEAKED;
                    res_off_c = off_reg[ROFF_W-1:0];
                    zb_c      = (ZB_W'(req_reg) > room) ? room : ZB_W'(req_reg);
                end
            end
            default:
            begin
                stat_c = STAT_ZERO_SIZE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            rsp_valid_reg   <= 1'b0;
            bump_cursor_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                heads_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ev_go && cur_we_c)
            begin
                bump_cursor_reg <= next_cur[CUR_W-1:0];
            end
            if (ev_go && head_we_c)
            begin
                heads_reg[head_widx_c] <= head_wdata_c;
            end
        end
    end

    // Hold the request fields; capture the head token during lookup.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op_t'(operation);
            req_reg     <= req_size;
            off_reg     <= free_offset;
            rounded_reg <= rounded_c;
            cls_reg     <= cls_dec;
            has_cls_reg <= has_cls_dec;
        end
        if (state_reg == S_LOOK)
        begin
            tok_reg <= head_rd;
        end
        if (ev_go)
        begin
            res_off_reg <= res_off_c;
            stat_reg    <= stat_c;
            zb_reg      <= zb_c;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign result_offset = res_off_reg;
    assign status        = stat_reg;
    assign zero_bytes    = zb_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    `SCSA_ASSERT_NEXT(a_accept_to_lookup, clk, rst_n, accept,
        state_reg == S_LOOK, "request not looked up after accept")
    `SCSA_ASSERT_NOW(a_cursor_in_heap, clk, rst_n, 1'b1,
        bump_cursor_reg <= CUR_W'(HEAP_BYTES), "bump cursor past heap")
    `SCSA_ASSERT_NOW(a_recycle_no_clear, clk, rst_n,
        rsp_valid_reg && (stat_reg == STAT_RECYCLED), zb_reg == '0,
        "recycled slot reports bytes to clear")
    `SCSA_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, state_reg == S_CLEAR,
        !rsp_valid_reg && !tag_we_c || !ev_go, "evaluate during tag clear")

endmodule

// File: sim/size_class_slab_allocator_test.sv
// Self-checking testbench for the size-class slab allocator.
// Depends on scsa_pkg and the size_class_slab_allocator RTL; reads no files.
// Drives a directed table, then random alloc/free traffic, against an in-bench heap model.

module size_class_slab_allocator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import scsa_pkg::*;

    // Random requests after the directed table.
    localparam int unsigned RANDOM_ITEMS = 1000;
    // Receiver hold-off long enough to back the block up into its request port.
    localparam int unsigned HOLD_CYCLES  = 200;
    // Cycles with no handshake before giving up; leave ample room for the
    // tag sweep after reset.
    localparam int unsigned STALL_LIMIT  = 4 * SLOT_COUNT;
    // Drain time after the last response.
    localparam int unsigned DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [ROFF_W-1:0] offset;
        status_t           stat;
        logic [ZB_W-1:0]   zero;
    } slab_result_t;

    typedef struct {
        op_t          op;
        int unsigned  size;
        int unsigned  off;
        bit           typed;
        slab_result_t want;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic                operation = 1'b0;
    logic [REQ_W-1:0]    req_size = '0;
    logic [OFF_W-1:0]    free_offset = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [ROFF_W-1:0]   result_offset;
    logic [STAT_W-1:0]   status;
    logic [ZB_W-1:0]     zero_bytes;

    // Heap model: bump cursor, per-class LIFO heads (slot + 1, 0 = empty),
    // per-slot tags and next links. Tags start uncarved, heads empty.
    int unsigned         heap_cursor = 0;
    bit [TOK_W-1:0]      list_head [NUM_CLASSES];
    bit [TAG_W-1:0]      slot_tag  [SLOT_COUNT];
    bit [TOK_W-1:0]      slot_link [SLOT_COUNT];

    // Offsets the stimulus aims frees at, kept in step with the heap model.
    int unsigned         live_offsets[$];
    int unsigned         freed_offsets[$];
    int unsigned         wide_offsets[$];

    // Results owed by the block, oldest first.
    slab_result_t        pending_slab_results[$];
    stim_row_t           directed_rows[$];

    int unsigned         fail_count = 0;
    int unsigned         responses_seen = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         hold_requests = 0;
    int unsigned         hold_seen = 0;
    int unsigned         hold_left = 0;
    bit                  sender_calm = 1'b0;

    size_class_slab_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .operation     (operation),
        .req_size      (req_size),
        .free_offset   (free_offset),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .result_offset (result_offset),
        .status        (status),
        .zero_bytes    (zero_bytes)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one accepted request to the heap model and return the result the
    // block owes for it. Also keep the stimulus pools of target offsets current.
    function automatic slab_result_t apply_slab_request(input op_t op,
                                                        input int unsigned size_in,
                                                        input int unsigned off_in);
        slab_result_t res;
        int unsigned  rounded;
        int unsigned  grant;
        int unsigned  cls;
        int unsigned  slot;
        int unsigned  tag;
        int unsigned  room;
        int unsigned  next_cursor;
        bit           has_cls;

        res.offset = '0;
        res.stat   = STAT_ZERO_SIZE;
        res.zero   = '0;

        if (op == OP_ALLOC) begin
            if (size_in == 0)
                return res;
            rounded = (size_in + 7) & ~32'd7;
            has_cls = 1'b0;
            cls     = NUM_CLASSES;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (!has_cls && rounded <= (SLOT_STRIDE << c)) begin
                    cls     = c;
                    has_cls = 1'b1;
                end
            end
            grant = rounded;
            if (has_cls) begin
                // Pop the class list; a head that does not point at a FREE slot
                // of this class is dropped and the request falls to the bump path.
                if (list_head[cls] != 0) begin
                    slot = list_head[cls] - 1;
                    if (slot < SLOT_COUNT && slot_tag[slot] == TAG_W'(cls + 1)) begin
                        slot_tag[slot] = TAG_W'(cls + 1 + NUM_CLASSES);
                        list_head[cls] = slot_link[slot];
                        res.offset     = ROFF_W'(slot * SLOT_STRIDE);
                        res.stat       = STAT_RECYCLED;
                        live_offsets.push_back(slot * SLOT_STRIDE);
                        return res;
                    end
                    list_head[cls] = '0;
                end
                grant = SLOT_STRIDE << cls;
            end
            next_cursor = heap_cursor + grant;
            if (next_cursor > HEAP_BYTES) begin
                res.stat = STAT_EXHAUSTED;
                return res;
            end
            res.offset = ROFF_W'(heap_cursor);
            res.stat   = STAT_BUMPED;
            res.zero   = ZB_W'(grant);
            if (has_cls) begin
                slot_tag[heap_cursor / SLOT_STRIDE] = TAG_W'(cls + 1 + NUM_CLASSES);
                live_offsets.push_back(heap_cursor);
            end
            else begin
                wide_offsets.push_back(heap_cursor);
            end
            heap_cursor = next_cursor;
            return res;
        end

        if (off_in >= HEAP_BYTES) begin
            res.stat = STAT_OUT_HEAP;
            return res;
        end
        if ((off_in % SLOT_STRIDE) != 0) begin
            res.stat = STAT_MISALIGN;
            return res;
        end
        slot = off_in / SLOT_STRIDE;
        tag  = slot_tag[slot];
        res.offset = ROFF_W'(off_in);
        if (tag > NUM_CLASSES && tag <= 2 * NUM_CLASSES) begin
            // Live slot: mark it free and push it on its class list.
            cls            = tag - 1 - NUM_CLASSES;
            slot_tag[slot] = TAG_W'(cls + 1);
            slot_link[slot] = list_head[cls];
            list_head[cls] = TOK_W'(slot + 1);
            res.stat       = STAT_FREED;
            res.zero       = ZB_W'(SLOT_STRIDE << cls);
            foreach (live_offsets[i]) begin
                if (live_offsets[i] == off_in) begin
                    live_offsets.delete(i);
                    break;
                end
            end
            freed_offsets.push_back(off_in);
            if (freed_offsets.size() > 32)
                void'(freed_offsets.pop_front());
        end
        else begin
            // Anything else leaks; the clear length is capped at the heap end.
            room     = HEAP_BYTES - off_in;
            res.stat = STAT_LEAKED;
            res.zero = ZB_W'((size_in > room) ? room : size_in);
        end
        return res;
    endfunction

    task automatic add_row(input op_t op, input int unsigned size, input int unsigned off,
                           input bit typed, input int unsigned want_off,
                           input status_t want_stat, input int unsigned want_zero);
        stim_row_t row;

        row.op          = op;
        row.size        = size;
        row.off         = off;
        row.typed       = typed;
        row.want.offset = ROFF_W'(want_off);
        row.want.stat   = want_stat;
        row.want.zero   = ZB_W'(want_zero);
        directed_rows.push_back(row);
    endtask

    // Offer one request and hold it until accepted; predict at the accept edge.
    // A typed expectation replaces the model's answer, but the model still advances.
    task automatic send_request(input op_t op, input int unsigned size, input int unsigned off,
                                input bit typed, input slab_result_t want);
        slab_result_t predicted;

        if (!sender_calm) begin
            while ($urandom_range(99) < 17) begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_valid   <= 1'b1;
        operation   <= op;
        req_size    <= REQ_W'(size);
        free_offset <= OFF_W'(off);
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = apply_slab_request(op, size, off);
        pending_slab_results.push_back(typed ? want : predicted);
    endtask

    function automatic int unsigned draw_alloc_size();
        int unsigned pick;
        int unsigned cls;

        pick = $urandom_range(99);
        cls  = $urandom_range(NUM_CLASSES - 1);
        if (pick < 45)
            return $urandom_range(1, 64);
        else if (pick < 65)
            return $urandom_range(65, 1024);
        else if (pick < 80)
            return (SLOT_STRIDE << cls) + $urandom_range(0, 1);
        else if (pick < 90)
            return $urandom_range(1025, 4096);
        else if (pick < 93)
            return $urandom_range(4097, 65536);
        else if (pick < 96)
            return 0;
        else if (pick < 98)
            return $urandom_range(1048577, 2097151);
        else
            return $urandom_range(1, 7);
    endfunction

    // Mostly well-formed churn: allocations and frees of live slots, with
    // double frees, interior and above-class slots, misaligned and
    // out-of-heap offsets mixed in as noise.
    task automatic draw_heap_request(output op_t op, output int unsigned size,
                                     output int unsigned off);
        int unsigned pick;

        op   = OP_ALLOC;
        size = 0;
        off  = $urandom_range(0, 2097151);
        if ($urandom_range(99) < 55) begin
            size = draw_alloc_size();
            return;
        end
        op   = OP_FREE;
        size = ($urandom_range(1) != 0) ? $urandom_range(0, 2097151) : $urandom_range(0, 64);
        pick = $urandom_range(99);
        if (pick < 65 && live_offsets.size() != 0)
            off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
        else if (pick < 73 && freed_offsets.size() != 0)
            off = freed_offsets[$urandom_range(0, freed_offsets.size() - 1)];
        else if (pick < 80 && live_offsets.size() != 0)
            off = live_offsets[$urandom_range(0, live_offsets.size() - 1)]
                  + SLOT_STRIDE * $urandom_range(1, 3);
        else if (pick < 85 && wide_offsets.size() != 0)
            off = wide_offsets[$urandom_range(0, wide_offsets.size() - 1)];
        else if (pick < 90)
            off = ($urandom_range(0, HEAP_BYTES / SLOT_STRIDE - 1) * SLOT_STRIDE)
                  + $urandom_range(1, SLOT_STRIDE - 1);
        else if (pick < 95)
            off = $urandom_range(HEAP_BYTES, 2097151);
        else
            off = $urandom_range(0, HEAP_BYTES / SLOT_STRIDE - 1) * SLOT_STRIDE;
    endtask

    // Receiver: random stalls, a calm stretch by response count, and a long
    // hold-off whenever the stimulus asks for one.
    always @(posedge clk)
    begin
        if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end
        else if (responses_seen >= 350 && responses_seen < 500) begin
            rsp_ready <= 1'b1;
        end
        else begin
            rsp_ready <= ($urandom_range(99) >= 17);
        end
    end

    // Compare each response with the oldest outstanding expectation.
    always @(posedge clk)
    begin : check_responses
        slab_result_t want;

        if (rst_n && rsp_valid && rsp_ready) begin
            if (pending_slab_results.size() == 0) begin
                $error("response with no request outstanding: offset %0d status %0d",
                       result_offset, status);
                fail_count++;
            end
            else begin
                want = pending_slab_results.pop_front();
                if (result_offset !== want.offset) begin
                    $error("result_offset: expected %0d, got %0d", want.offset, result_offset);
                    fail_count++;
                end
                if (status !== want.stat) begin
                    $error("status: expected %0d, got %0d", want.stat, status);
                    fail_count++;
                end
                if (zero_bytes !== want.zero) begin
                    $error("zero_bytes: expected %0d, got %0d", want.zero, zero_bytes);
                    fail_count++;
                end
            end
            responses_seen <= responses_seen + 1;
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        op_t          op;
        int unsigned  size;
        int unsigned  off;
        slab_result_t unused;

        unused = '0;

        // Fresh heap: cursor 0, so the first bumps land at known offsets.
        add_row(OP_ALLOC, 0,       0,       1'b1, 0,    STAT_ZERO_SIZE, 0);
        add_row(OP_ALLOC, 1,       0,       1'b1, 0,    STAT_BUMPED,    8);
        add_row(OP_ALLOC, 8,       0,       1'b0, 0,    STAT_BUMPED,    0);
        add_row(OP_ALLOC, 9,       0,       1'b0, 0,    STAT_BUMPED,    0);
        add_row(OP_ALLOC, 1024,    0,       1'b0, 0,    STAT_BUMPED,    0);
        // Above the largest class: bumped by the rounded size, left untagged.
        add_row(OP_ALLOC, 1025,    2097151, 1'b0, 0,    STAT_BUMPED,    0);
        add_row(OP_ALLOC, 2097151, 0,       1'b1, 0,    STAT_EXHAUSTED, 0);
        add_row(OP_FREE,  0,       0,       1'b0, 0,    STAT_FREED,     0);
        // Double free leaks with the advisory length.
        add_row(OP_FREE,  5,       0,       1'b1, 0,    STAT_LEAKED,    5);
        add_row(OP_ALLOC, 3,       0,       1'b0, 0,    STAT_RECYCLED,  0);
        // Above-class slot leaks, clear length capped at the heap end.
        add_row(OP_FREE,  2097151, 1056,    1'b1, 1056, STAT_LEAKED,    1047520);
        add_row(OP_FREE,  0,       2097151, 1'b1, 0,    STAT_OUT_HEAP,  0);
        add_row(OP_FREE,  0,       1048576, 1'b1, 0,    STAT_OUT_HEAP,  0);
        add_row(OP_FREE,  0,       1048575, 1'b1, 0,    STAT_MISALIGN,  0);
        add_row(OP_FREE,  0,       7,       1'b1, 0,    STAT_MISALIGN,  0);
        // Last slot of the heap, never carved.
        add_row(OP_FREE,  2097151, 1048568, 1'b1, 1048568, STAT_LEAKED, 8);
        // Interior of the 16-byte slot at offset 16.
        add_row(OP_FREE,  0,       24,      1'b1, 24,   STAT_LEAKED,    0);
        add_row(OP_FREE,  0,       32,      1'b0, 0,    STAT_FREED,     0);
        add_row(OP_FREE,  0,       16,      1'b0, 0,    STAT_FREED,     0);
        add_row(OP_ALLOC, 1000,    0,       1'b0, 0,    STAT_RECYCLED,  0);
        add_row(OP_ALLOC, 512,     0,       1'b0, 0,    STAT_BUMPED,    0);
        add_row(OP_FREE,  0,       8,       1'b0, 0,    STAT_FREED,     0);
        add_row(OP_ALLOC, 8,       0,       1'b0, 0,    STAT_RECYCLED,  0);
        add_row(OP_ALLOC, 9,       0,       1'b0, 0,    STAT_RECYCLED,  0);
        add_row(OP_ALLOC, 1048576, 0,       1'b1, 0,    STAT_EXHAUSTED, 0);

        // Hold reset, then release it; the block then sweeps its tag memory
        // with req_ready low, and the first request simply waits it out.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].size, directed_rows[i].off,
                         directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Ask the receiver for a long hold-off and keep offering requests,
            // so the response register fills and the request port stalls.
            if (n == 150)
                hold_requests <= hold_requests + 1;
            // Drop valid and wait for every owed response before continuing.
            if (n == 600) begin
                req_valid <= 1'b0;
                @(posedge clk);
                while (pending_slab_results.size() != 0)
                    @(posedge clk);
            end
            sender_calm = (n >= 300 && n < 450);
            draw_heap_request(op, size, off);
            send_request(op, size, off, 1'b0, unused);
        end

        req_valid <= 1'b0;
        while (pending_slab_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
